>>> sv/rts_pkg.sv
`default_nettype none

package rts_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_WIDTH_DEF = 32;

    // Only the first sixteen slots are reachable by the four-bit slot field.
    localparam int SCAN_LIMIT = 16;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 4;
    localparam int PERIOD_W = 32;
    localparam int LIMIT_W  = 17;
    localparam int COUNT_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic               fire;
        logic               stop;
        logic [COUNT_W-1:0] count;
    } fire_t;

endpackage

`default_nettype wire

>>> sv/rts_ram.sv
`default_nettype none

module rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/rts_fire_unit.sv
`default_nettype none

module rts_fire_unit
    import rts_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  en,
    input  wire logic                  running,
    input  wire logic [TIME_WIDTH-1:0] now,
    input  wire logic [TIME_WIDTH-1:0] deadline,
    input  wire logic [TIME_WIDTH-1:0] addend,
    input  wire logic [COUNT_W-1:0]    count,
    input  wire logic [LIMIT_W-1:0]    limit,
    output fire_t                      res,
    output logic      [TIME_WIDTH-1:0] sum
);

    logic [COUNT_W-1:0] count_inc;

    assign sum       = now + addend;
    assign count_inc = (count == COUNT_MAX) ? count : count + COUNT_W'(1);

    always_comb begin
        res.fire  = en && running && (deadline == now);
        res.count = count_inc;
        // Stop once the count reaches a non-negative limit.
        res.stop  = !($signed(limit) < 0 || $signed({1'b0, count_inc}) < $signed(limit));
    end

endmodule

`default_nettype wire

>>> sv/repeating_timer_scheduler_top.sv
`default_nettype none

// Bank of repeating timer slots driven by a tick command. A start transaction arms a slot
// with a period and a repeat limit (negative repeats forever, a zero period is ignored), a
// stop transaction disarms it. A tick advances the time by one and then walks the first
// min(NUM_TIMERS, 16) slots through one shared add-and-compare unit, one slot per cycle
// over a slot memory with one read and one write port while the result channel keeps up;
// a due slot waits while an earlier result is still held and the channel stalls. Each due
// slot yields one result transaction in slot order, and tlast marks the final result of
// the tick; a tick with nothing due yields none. The input is not ready while a tick is
// being processed.
module repeating_timer_scheduler_top
    import rts_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // timer_id [3:0], period_ms [35:4], repeat_limit [52:36]
    input  wire logic [55:0] s_tdata,
    // command [1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // fired_id [3:0], fire_count [19:4], now_stopped [20]
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SCAN_N = (NUM_TIMERS < SCAN_LIMIT) ? NUM_TIMERS : SCAN_LIMIT;
    localparam int REC_W  = COUNT_W + LIMIT_W + 2 * TIME_WIDTH;

    state_t state_reg, state_next;

    logic [TIME_WIDTH-1:0] now_reg;
    logic [NUM_TIMERS-1:0] running_reg;
    logic [IDX_W:0]        rd_cnt_reg;
    logic                  ev_valid_reg;
    logic [IDX_W-1:0]      ev_idx_reg;

    logic               hold_valid_reg;
    logic [ID_W-1:0]    hold_id_reg;
    logic [COUNT_W-1:0] hold_count_reg;
    logic               hold_stop_reg;

    logic               out_valid_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_stop_reg;
    logic               out_last_reg;

    cmd_t                  cmd;
    logic [ID_W-1:0]       in_id;
    logic [PERIOD_W-1:0]   in_period;
    logic [LIMIT_W-1:0]    in_limit;
    logic [TIME_WIDTH-1:0] in_period_t;
    logic [IDX_W-1:0]      in_addr;
    logic                  in_id_ok;
    logic                  accept;
    logic                  start_ok;
    logic                  stop_ok;
    logic                  tick_acc;

    logic [REC_W-1:0]      rd_rec;
    logic [REC_W-1:0]      wr_rec;
    logic [TIME_WIDTH-1:0] rec_deadline;
    logic [TIME_WIDTH-1:0] rec_period;
    logic [LIMIT_W-1:0]    rec_limit;
    logic [COUNT_W-1:0]    rec_count;

    fire_t                 fu_res;
    logic [TIME_WIDTH-1:0] fu_sum;
    logic [TIME_WIDTH-1:0] fu_addend;

    logic             out_free;
    logic             advance;
    logic             eval_fire;
    logic             scan_end;
    logic             push_hold;
    logic             flush_push;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;

    assign cmd         = cmd_t'(s_tuser);
    assign in_id       = s_tdata[3:0];
    assign in_period   = s_tdata[35:4];
    assign in_limit    = s_tdata[52:36];
    assign in_period_t = TIME_WIDTH'(in_period);
    assign in_addr     = IDX_W'(in_id);
    assign in_id_ok    = 32'(in_id) < 32'(NUM_TIMERS);

    assign accept   = s_tvalid && s_tready;
    assign start_ok = accept && (cmd == CMD_START) && in_id_ok && (in_period != '0);
    assign stop_ok  = accept && (cmd == CMD_STOP) && in_id_ok;
    assign tick_acc = accept && (cmd == CMD_TICK);

    assign {rec_count, rec_limit, rec_period, rec_deadline} = rd_rec;

    assign fu_addend = (state_reg == ST_SCAN) ? rec_period : in_period_t;

    rts_fire_unit #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_fire (
        .en      (ev_valid_reg && (state_reg == ST_SCAN)),
        .running (running_reg[ev_idx_reg]),
        .now     (now_reg),
        .deadline(rec_deadline),
        .addend  (fu_addend),
        .count   (rec_count),
        .limit   (rec_limit),
        .res     (fu_res),
        .sum     (fu_sum)
    );

    rts_ram #(
        .WIDTH(REC_W),
        .DEPTH(NUM_TIMERS)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(wr_rec),
        .raddr(ram_raddr),
        .rdata(rd_rec)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_acc) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!hold_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        out_free   = !out_valid_reg || m_tready;
        eval_fire  = 1'b0;
        advance    = 1'b0;
        scan_end   = 1'b0;
        push_hold  = 1'b0;
        flush_push = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = in_addr;
        ram_raddr  = ev_idx_reg;
        wr_rec     = {{COUNT_W{1'b0}}, in_limit, in_period_t, fu_sum};
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_we   = start_ok;
            end
            ST_SCAN: begin
                eval_fire = fu_res.fire;
                // A second due slot can only be taken once the held result has moved on.
                advance   = !eval_fire || !hold_valid_reg || out_free;
                scan_end  = advance && (rd_cnt_reg == (IDX_W + 1)'(SCAN_N));
                push_hold = advance && eval_fire && hold_valid_reg;
                ram_we    = advance && eval_fire;
                ram_waddr = ev_idx_reg;
                ram_raddr = advance ? rd_cnt_reg[IDX_W-1:0] : ev_idx_reg;
                wr_rec    = {fu_res.count, rec_limit, rec_period,
                             fu_res.stop ? rec_deadline : fu_sum};
            end
            ST_FLUSH: begin
                flush_push = hold_valid_reg && out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            running_reg    <= '0;
            rd_cnt_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (tick_acc) begin
                now_reg      <= now_reg + TIME_WIDTH'(1);
                rd_cnt_reg   <= '0;
                ev_valid_reg <= 1'b0;
            end else if (advance) begin
                ev_valid_reg <= (rd_cnt_reg != (IDX_W + 1)'(SCAN_N));
                if (rd_cnt_reg != (IDX_W + 1)'(SCAN_N)) begin
                    rd_cnt_reg <= rd_cnt_reg + (IDX_W + 1)'(1);
                end
            end

            if (start_ok) begin
                running_reg[in_addr] <= 1'b1;
            end else if (stop_ok) begin
                running_reg[in_addr] <= 1'b0;
            end else if (advance && eval_fire && fu_res.stop) begin
                running_reg[ev_idx_reg] <= 1'b0;
            end

            if (advance && eval_fire) begin
                hold_valid_reg <= 1'b1;
            end else if (flush_push) begin
                hold_valid_reg <= 1'b0;
            end

            if (push_hold || flush_push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ev_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        end
        if (advance && eval_fire) begin
            hold_id_reg    <= ID_W'(ev_idx_reg);
            hold_count_reg <= fu_res.count;
            hold_stop_reg  <= fu_res.stop;
        end
        if (push_hold || flush_push) begin
            out_id_reg    <= hold_id_reg;
            out_count_reg <= hold_count_reg;
            out_stop_reg  <= hold_stop_reg;
            out_last_reg  <= flush_push;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_stop_reg, out_count_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

    ap_idle_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !hold_valid_reg)
        else $error("held result left behind after a tick");

    ap_tick_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_acc |=> (state_reg == ST_SCAN) && (rd_cnt_reg == '0) && !ev_valid_reg)
        else $error("tick did not start a scan");

    ap_scan_write_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) && ram_we) |-> ev_valid_reg && advance)
        else $error("slot write-back without a slot under evaluation");

    ap_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (rd_cnt_reg <= (IDX_W + 1)'(SCAN_N)))
        else $error("scan counter ran past the last slot");

    ap_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_hold || flush_push) |-> out_free)
        else $error("result register overwritten while full");

endmodule

`default_nettype wire

>>> tb/repeating_timer_scheduler_top_tb.sv
`timescale 1ns / 1ps

module repeating_timer_scheduler_top_tb
    import rts_pkg::*;
();

    localparam int SLOTS         = 16;
    localparam int IDLE_PCT      = 22;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 150;
    localparam int BURST_TICKS   = 40;
    localparam int CYCLE_LIMIT   = 4_000_000;

    localparam logic [CMD_W-1:0]   CMD_RESERVED  = 2'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_FOREVER = {LIMIT_W{1'b1}};
    localparam logic [LIMIT_W-1:0] LIMIT_MOST_NEG = {1'b1, {(LIMIT_W-1){1'b0}}};
    localparam logic [LIMIT_W-1:0] LIMIT_MAX     = {1'b0, {(LIMIT_W-1){1'b1}}};

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
        logic               stopped;
        logic               last;
    } expiry_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // Reference copy of the timer bank.
    logic [PERIOD_W-1:0]       sched_time;
    logic [PERIOD_W-1:0]       sched_deadline [SLOTS];
    logic [PERIOD_W-1:0]       sched_period   [SLOTS];
    logic signed [LIMIT_W-1:0] sched_limit    [SLOTS];
    logic [COUNT_W-1:0]        sched_count    [SLOTS];
    logic                      sched_armed    [SLOTS];

    expiry_t pending_expiries [$];

    bit stall_en = 1'b1;
    int mismatches;
    int items_sent;
    int ticks_sent;
    int expiries_checked;
    int cycles;

    repeating_timer_scheduler_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d expiries outstanding.",
                     cycles, pending_expiries.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= stall_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    function automatic void advance_schedule(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                             logic [PERIOD_W-1:0] period,
                                             logic [LIMIT_W-1:0] limit);
        expiry_t rec;
        int      lim_i;
        int      cnt_i;
        int      first_new;
        logic    stop_now;
        if (cmd == CMD_START) begin
            if (period != '0) begin
                sched_period[id]   = period;
                sched_deadline[id] = sched_time + period;
                sched_limit[id]    = limit;
                sched_count[id]    = '0;
                sched_armed[id]    = 1'b1;
            end
        end else if (cmd == CMD_STOP) begin
            sched_armed[id] = 1'b0;
        end else if (cmd == CMD_TICK) begin
            ticks_sent++;
            sched_time = sched_time + 1;
            first_new  = pending_expiries.size();
            for (int i = 0; i < SLOTS; i++) begin
                if (sched_armed[i] && sched_deadline[i] == sched_time) begin
                    if (sched_count[i] != COUNT_MAX) sched_count[i]++;
                    lim_i    = int'(sched_limit[i]);
                    cnt_i    = int'(sched_count[i]);
                    stop_now = !(lim_i < 0 || cnt_i < lim_i);
                    if (stop_now) begin
                        sched_armed[i] = 1'b0;
                    end else begin
                        sched_deadline[i] = sched_time + sched_period[i];
                    end
                    rec.id      = i[ID_W-1:0];
                    rec.count   = sched_count[i];
                    rec.stopped = stop_now;
                    rec.last    = 1'b0;
                    pending_expiries.push_back(rec);
                end
            end
            if (pending_expiries.size() > first_new) begin
                pending_expiries[pending_expiries.size()-1].last = 1'b1;
            end
        end
    endfunction

    always @(posedge aclk) begin : check_expiries
        expiry_t want;
        expiry_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.id      = m_tdata[3:0];
            got.count   = m_tdata[19:4];
            got.stopped = m_tdata[20];
            got.last    = m_tlast;
            if (pending_expiries.size() == 0) begin
                $display("%0t: unexpected expiry id=%0d count=%0d stopped=%0b last=%0b",
                         $time, got.id, got.count, got.stopped, got.last);
                mismatches++;
            end else begin
                want = pending_expiries.pop_front();
                expiries_checked++;
                if (got.id != want.id || got.count != want.count ||
                    got.stopped != want.stopped || got.last != want.last) begin
                    $display("%0t: expected id=%0d count=%0d stopped=%0b last=%0b",
                             $time, want.id, want.count, want.stopped, want.last);
                    $display("%0t: actual   id=%0d count=%0d stopped=%0b last=%0b",
                             $time, got.id, got.count, got.stopped, got.last);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [PERIOD_W-1:0] period,
                             input logic [LIMIT_W-1:0] limit);
        while (stall_en && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, limit, period, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_schedule(cmd, id, period, limit);
        items_sent++;
    endtask

    task automatic drain_expiries();
        s_tvalid <= 1'b0;
        while (pending_expiries.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(9))
            7:       return $urandom;
            8:       return '0;
            9:       return $urandom_range(7, 40);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(9))
            0, 1, 2: return LIMIT_FOREVER;
            7:       return LIMIT_W'($urandom);
            8:       return LIMIT_MOST_NEG;
            9:       return LIMIT_MAX;
            default: return LIMIT_W'($urandom_range(0, 4));
        endcase
    endfunction

    task automatic test_basic_expiry();
        send_item(CMD_START, 4'd0, 32'd1, 17'd2);
        send_item(CMD_START, 4'd15, 32'd2, 17'd0);
        repeat (3) send_item(CMD_TICK, 4'd0, 32'd0, 17'd0);
    endtask

    task automatic test_ignored_items();
        send_item(CMD_START, 4'd3, 32'd0, LIMIT_FOREVER);
        send_item(CMD_RESERVED, 4'hF, 32'hFFFF_FFFF, 17'h1FFFF);
        send_item(CMD_STOP, 4'd5, 32'd0, 17'd0);
        send_item(CMD_TICK, 4'hF, 32'hFFFF_FFFF, 17'h1FFFF);
    endtask

    task automatic test_restart_and_stop();
        send_item(CMD_START, 4'd1, 32'd3, LIMIT_FOREVER);
        send_item(CMD_TICK, 4'd0, 32'd0, 17'd0);
        send_item(CMD_START, 4'd1, 32'd2, LIMIT_FOREVER);
        send_item(CMD_TICK, 4'd0, 32'd0, 17'd0);
        send_item(CMD_TICK, 4'd0, 32'd0, 17'd0);
        send_item(CMD_START, 4'd2, 32'd1, 17'd1);
        send_item(CMD_STOP, 4'd1, 32'd0, 17'd0);
        send_item(CMD_TICK, 4'd0, 32'd0, 17'd0);
    endtask

    task automatic test_extreme_fields();
        send_item(CMD_START, 4'd7, 32'hFFFF_FFFF, LIMIT_MAX);
        send_item(CMD_START, 4'd8, 32'h8000_0000, LIMIT_MOST_NEG);
        send_item(CMD_STOP, 4'd7, 32'd0, 17'd0);
        send_item(CMD_TICK, 4'd0, 32'd0, 17'd0);
    endtask

    task automatic test_full_scan();
        for (int i = 0; i < SLOTS; i++) send_item(CMD_START, i[ID_W-1:0], 32'd1, 17'd2);
        repeat (2) send_item(CMD_TICK, 4'd0, 32'd0, 17'd0);
    endtask

    task automatic test_random_traffic();
        int  stop_at;
        bit  paused;
        stop_at = items_sent + RANDOM_ITEMS;
        paused  = 1'b0;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(CMD_START, ID_W'($urandom_range(15)), pick_period(),
                              pick_limit());
                end
                repeat ($urandom_range(2, 12)) begin
                    if ($urandom_range(99) < 10) begin
                        send_item(CMD_STOP, ID_W'($urandom_range(15)), $urandom,
                                  LIMIT_W'($urandom));
                    end
                    send_item(CMD_TICK, ID_W'($urandom_range(15)), $urandom,
                              LIMIT_W'($urandom));
                end
            end else begin
                send_item(CMD_W'($urandom_range(3)), ID_W'($urandom_range(15)),
                          pick_period(), LIMIT_W'($urandom));
            end
            if (!paused && items_sent >= stop_at - RANDOM_ITEMS / 2) begin
                // Hold the sender until every pending expiry has been delivered.
                drain_expiries();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_unstalled_ticks();
        stall_en = 1'b0;
        for (int i = 0; i < SLOTS; i++) send_item(CMD_STOP, i[ID_W-1:0], 32'd0, 17'd0);
        send_item(CMD_START, 4'd0, 32'd1, LIMIT_FOREVER);
        send_item(CMD_START, 4'd1, 32'd1, LIMIT_MAX);
        repeat (BURST_TICKS) send_item(CMD_TICK, 4'd0, 32'd0, 17'd0);
        drain_expiries();
        stall_en = 1'b1;
    endtask

    initial begin
        sched_time = '0;
        for (int i = 0; i < SLOTS; i++) begin
            sched_deadline[i] = '0;
            sched_period[i]   = '0;
            sched_limit[i]    = '0;
            sched_count[i]    = '0;
            sched_armed[i]    = 1'b0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_expiry();
        test_ignored_items();
        test_restart_and_stop();
        test_extreme_fields();
        test_full_scan();
        test_random_traffic();
        test_unstalled_ticks();

        drain_expiries();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d transactions including %0d ticks; checked %0d timer expiries.",
                 items_sent, ticks_sent, expiries_checked);
        $display("Covered directed corner cases, random start/stop/tick traffic with stalls,");
        $display("a full sixteen-slot expiry and a %0d-tick run without stalls.", BURST_TICKS);
        if (mismatches == 0 && pending_expiries.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
sv/rts_pkg.sv
sv/rts_ram.sv
sv/rts_fire_unit.sv
sv/repeating_timer_scheduler_top.sv
tb/repeating_timer_scheduler_top_tb.sv
